[sv/command_line_argument_splitter_top_defines.svh]
// Assertion macros for the command line argument splitter.
`ifndef COMMAND_LINE_ARGUMENT_SPLITTER_TOP_DEFINES_SVH
`define COMMAND_LINE_ARGUMENT_SPLITTER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CLS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define CLS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/cls_pkg.sv]
// Types and constants shared by the command line argument splitter.
package cls_pkg;

   localparam logic [2:0] MODE_SPACE      = 3'd0;
   localparam logic [2:0] MODE_ARG        = 3'd1;
   localparam logic [2:0] MODE_QUOTED     = 3'd2;
   localparam logic [2:0] MODE_ARG_ESC    = 3'd5;
   localparam logic [2:0] MODE_QUOTED_ESC = 3'd6;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SPACE  = 8'h20;

   localparam logic [1:0] KIND_BYTE = 2'd0;
   localparam logic [1:0] KIND_END  = 2'd1;
   localparam logic [1:0] KIND_DONE = 2'd2;

   localparam logic [7:0] MAX_ARGS_RESET = 8'd31;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] out_char;
      logic [7:0] arg_index;
      logic [7:0] arg_count;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
      logic [2:0] mode;
      logic [7:0] args;
   } step_type;

endpackage

[sv/cls_step.sv]
// Per-beat split decision: next mode, next count and up to two results.
module cls_step import cls_pkg::*; (
   input  logic [2:0] cur_mode,
   input  logic [7:0] cur_args,
   input  logic [7:0] max_args,
   input  logic [7:0] ch,
   output step_type   step
);

   logic keep;
   logic end_arg;
   logic [2:0] mode_next;
   logic [7:0] args_inc;

   assign args_inc = cur_args + 8'd1;

   always_comb begin
      keep = 1'b0;
      end_arg = 1'b0;
      mode_next = cur_mode;
      unique case (cur_mode)
         MODE_ARG: begin
            if (ch == CH_SPACE) begin
               end_arg = 1'b1;
            end else if (ch == CH_BSLASH) begin
               mode_next = MODE_ARG_ESC;
            end else begin
               keep = 1'b1;
            end
         end
         MODE_QUOTED: begin
            if (ch == CH_QUOTE) begin
               end_arg = 1'b1;
            end else if (ch == CH_BSLASH) begin
               mode_next = MODE_QUOTED_ESC;
            end else begin
               keep = 1'b1;
            end
         end
         MODE_ARG_ESC, MODE_QUOTED_ESC: begin
            keep = (ch == CH_BSLASH) || (ch == CH_QUOTE) || (ch == CH_SPACE);
            mode_next = cur_mode & 3'b011;
         end
         default: begin
            if (ch == CH_SPACE) begin
               mode_next = MODE_SPACE;
            end else if (ch == CH_QUOTE) begin
               mode_next = MODE_QUOTED;
            end else if (ch == CH_BSLASH) begin
               mode_next = MODE_ARG_ESC;
            end else begin
               mode_next = MODE_ARG;
               keep = 1'b1;
            end
         end
      endcase
   end

   always_comb begin
      step = '0;
      step.mode = cur_mode;
      step.args = cur_args;
      priority if (ch == CH_NUL) begin
         step.mode = MODE_SPACE;
         step.args = 8'd0;
         if ((cur_mode != MODE_SPACE) && (cur_args < max_args)) begin
            step.count = 2'd2;
            step.first.kind = KIND_END;
            step.first.arg_index = cur_args;
            step.second.kind = KIND_DONE;
            step.second.arg_count = args_inc;
            step.second.last = 1'b1;
         end else begin
            step.count = 2'd1;
            step.first.kind = KIND_DONE;
            step.first.arg_count = cur_args;
            step.first.last = 1'b1;
         end
      end else if (cur_args >= max_args) begin
         step.count = 2'd0;
      end else if (end_arg) begin
         step.count = 2'd1;
         step.first.kind = KIND_END;
         step.first.arg_index = cur_args;
         step.first.last = 1'b1;
         step.args = args_inc;
         step.mode = MODE_SPACE;
      end else begin
         step.count = keep ? 2'd1 : 2'd0;
         step.first.kind = KIND_BYTE;
         step.first.out_char = ch;
         step.first.arg_index = cur_args;
         step.first.last = 1'b1;
         step.mode = mode_next;
      end
   end

endmodule

[sv/command_line_argument_splitter_top.sv]
// A result beat is written into the result queue when its byte beat is taken.
// Throughput: byte beats are taken one per cycle while the queue has room for
// two results; a line end with an open argument below max_args gives two result
// beats, drained one per cycle while rsp_tready is high, from a DEPTH-entry result queue.
// Synchronous reset clears mode, argument count, queue and sets max_args to 31.
`include "command_line_argument_splitter_top_defines.svh"
module command_line_argument_splitter_top import cls_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] out_char, [15:8] arg_index, [23:16] arg_count
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [7:0]    max_args_ff;
   logic [2:0]    mode_ff;
   logic [7:0]    args_ff;
   rsp_type       queue_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   step_type      step;
   logic          push;
   logic          pop;
   logic [PW-1:0] wr_ptr_nx;
   rsp_type       head;

   function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] ptr);
      return (ptr == PW'(DEPTH - 1)) ? '0 : ptr + PW'(1);
   endfunction

   cls_step u_step (
      .cur_mode (mode_ff),
      .cur_args (args_ff),
      .max_args (max_args_ff),
      .ch       (req_tdata),
      .step     (step)
   );

   assign csr_ready  = 1'b1;
   assign req_tready = (count_ff <= CW'(DEPTH - 2));
   assign rsp_tvalid = (count_ff != '0);
   assign push       = req_tvalid && req_tready;
   assign pop        = rsp_tvalid && rsp_tready;
   assign wr_ptr_nx  = ptr_inc(wr_ptr_ff);

   assign head      = queue_ff[rd_ptr_ff];
   assign rsp_tdata = {head.arg_count, head.arg_index, head.out_char};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      if (push) begin
         unique case (step.count)
            2'd1:    wr_ptr_in = wr_ptr_nx;
            2'd2:    wr_ptr_in = ptr_inc(wr_ptr_nx);
            default: wr_ptr_in = wr_ptr_ff;
         endcase
         count_in = count_in + CW'(step.count);
      end
      if (pop) begin
         count_in = count_in - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_args_ff <= MAX_ARGS_RESET;
         mode_ff     <= MODE_SPACE;
         args_ff     <= 8'd0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            max_args_ff <= csr_data;
         end
         if (push) begin
            mode_ff <= step.mode;
            args_ff <= step.args;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && (step.count != 2'd0)) begin
         queue_ff[wr_ptr_ff] <= step.first;
      end
      if (push && (step.count == 2'd2)) begin
         queue_ff[wr_ptr_nx] <= step.second;
      end
   end

   `CLS_ASSERT_NOW(a_queue_bound, 1'b1, count_ff <= CW'(DEPTH), "result queue overflow")
   `CLS_ASSERT_NOW(a_done_is_last, rsp_tvalid && (rsp_tuser == KIND_DONE), rsp_tlast,
      "line done beat without tlast")
   `CLS_ASSERT_NEXT(a_line_end_clears, push && (req_tdata == CH_NUL),
      (mode_ff == MODE_SPACE) && (args_ff == 8'd0), "line end left state behind")

endmodule
